[rtl/upm_pkg.sv]
// ----------------------------------------------------------------------------
// upm_pkg
// Shared types, constants and coefficient tables for the mono to six-channel
// biquad upmixer.
// ----------------------------------------------------------------------------
package upm_pkg;

    localparam int SAMPLE_WIDTH   = 24;
    localparam int COEF_FRAC_BITS = 14;

    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 15;
    localparam int COEF_W    = COEF_FRAC_BITS + 2;
    localparam int MUL_B_W   = (COEF_W > GAIN_W) ? COEF_W : GAIN_W;
    localparam int PROD_W    = SAMPLE_WIDTH + MUL_B_W;
    // Five products plus the rounding bias.
    localparam int ACC_W     = PROD_W + 3;

    localparam int NUM_FILT  = 6;
    localparam int NUM_TERMS = 5;
    localparam int NUM_CH    = 6;
    localparam int FILT_AW   = 3;
    localparam int TERM_W    = 3;

    localparam int IN_TDATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((NUM_CH * SAMPLE_WIDTH + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_ONE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_TWO = 8'd3;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd23198;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]       t_coef;
    typedef logic signed [MUL_B_W-1:0]      t_mul_b;
    typedef logic signed [PROD_W-1:0]       t_prod;
    typedef logic signed [ACC_W-1:0]        t_acc;
    typedef logic signed [GAIN_W-1:0]       t_gain;

    // One history entry per filter.
    typedef struct packed {
        t_sample y2;
        t_sample y1;
        t_sample x2;
        t_sample x1;
    } t_hist;

    // Operation issued to the multiply-accumulate unit.
    typedef struct packed {
        logic valid;
        logic load;   // start a new sum
        logic gain;   // Q1.15 gain scaling instead of a biquad term
    } t_mac_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GAIN,
        ST_MAC,
        ST_HOLD
    } t_state;

    // Decimal coefficient in units of 1e-4, rounded to the coefficient grid
    // with ties away from zero.
    function automatic t_coef quant_coef(input longint e4);
        longint mag;
        longint r;
        mag = (e4 < 0) ? -e4 : e4;
        r   = ((mag << COEF_FRAC_BITS) + 64'sd5000) / 64'sd10000;
        return (e4 < 0) ? t_coef'(-r) : t_coef'(r);
    endfunction

    // Per shape: b0, b1, b2, -a1, -a2, so every term is simply added.
    localparam t_coef COEFS [3][NUM_TERMS] = '{
        '{quant_coef(6828), quant_coef(13657), quant_coef(6828),
          quant_coef(-11314), quant_coef(-6000)},
        '{quant_coef(9617), quant_coef(-19234), quant_coef(9617),
          quant_coef(19182), quant_coef(-9287)},
        '{quant_coef(4139), quant_coef(0), quant_coef(-4139),
          quant_coef(6384), quant_coef(-1722)}
    };

    // LPF, HPF800, BPF, BPF2, HPF2_800, LPF2
    localparam logic [1:0] FILT_SHAPE [NUM_FILT] = '{2'd0, 2'd1, 2'd2, 2'd2, 2'd1, 2'd0};

    function automatic t_coef coef_sel(input logic [FILT_AW-1:0] f,
                                       input logic [TERM_W-1:0] k);
        logic [1:0] shape;
        shape = FILT_SHAPE[f];
        return COEFS[shape][k];
    endfunction

endpackage

[rtl/upm_hist_ram.sv]
// ----------------------------------------------------------------------------
// upm_hist_ram
// Filter history memory: one entry per biquad, with a registered synchronous
// read. Entries not yet written read as zero.
// ----------------------------------------------------------------------------
module upm_hist_ram (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [upm_pkg::FILT_AW-1:0]   i_rd_addr,
    output upm_pkg::t_hist                o_rd_data,
    input  logic                          i_wr_en,
    input  logic [upm_pkg::FILT_AW-1:0]   i_wr_addr,
    input  upm_pkg::t_hist                i_wr_data
);

    upm_pkg::t_hist                 mem [upm_pkg::NUM_FILT];
    logic [upm_pkg::NUM_FILT-1:0]   r_valid;
    upm_pkg::t_hist                 r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // The read register holds between reads, so the controller reads each
    // entry it uses once per item.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_valid[i_rd_addr] ? mem[i_rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/upm_mac.sv]
// ----------------------------------------------------------------------------
// upm_mac
// Shared multiply-accumulate unit: registered product, then a rounding
// accumulator whose saturated, rescaled value is presented on o_y.
// ----------------------------------------------------------------------------
module upm_mac (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  upm_pkg::t_mac_op   i_op,
    input  upm_pkg::t_sample   i_a,
    input  upm_pkg::t_mul_b    i_b,
    output upm_pkg::t_sample   o_y
);

    localparam upm_pkg::t_acc GAIN_BIAS = upm_pkg::t_acc'(1) << (upm_pkg::GAIN_FRAC - 1);
    localparam upm_pkg::t_acc COEF_BIAS =
        upm_pkg::t_acc'(1) << (upm_pkg::COEF_FRAC_BITS - 1);
    localparam upm_pkg::t_sample SMAX = {1'b0, {(upm_pkg::SAMPLE_WIDTH-1){1'b1}}};
    localparam upm_pkg::t_sample SMIN = {1'b1, {(upm_pkg::SAMPLE_WIDTH-1){1'b0}}};

    upm_pkg::t_mac_op r_p_op;
    upm_pkg::t_prod   r_prod;
    upm_pkg::t_acc    r_acc;
    logic             r_acc_gain;
    upm_pkg::t_acc    scaled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_op <= '0;
        end else begin
            r_p_op <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= upm_pkg::t_prod'(i_a) * upm_pkg::t_prod'(i_b);
    end

    always_ff @(posedge i_clk) begin
        if (r_p_op.valid) begin
            if (r_p_op.load) begin
                r_acc      <= upm_pkg::t_acc'(r_prod) + (r_p_op.gain ? GAIN_BIAS : COEF_BIAS);
                r_acc_gain <= r_p_op.gain;
            end else begin
                r_acc <= r_acc + upm_pkg::t_acc'(r_prod);
            end
        end
    end

    // The arithmetic shift floors; the bias added at load rounds.
    always_comb begin
        scaled = r_acc_gain ? (r_acc >>> upm_pkg::GAIN_FRAC)
                            : (r_acc >>> upm_pkg::COEF_FRAC_BITS);
        if (scaled > upm_pkg::t_acc'(SMAX)) begin
            o_y = SMAX;
        end else if (scaled < upm_pkg::t_acc'(SMIN)) begin
            o_y = SMIN;
        end else begin
            o_y = upm_pkg::t_sample'(scaled);
        end
    end

endmodule

[rtl/mono_to_six_channel_biquad_upmix.sv]
// ----------------------------------------------------------------------------
// mono_to_six_channel_biquad_upmix
// Mono to six-channel upmixer built on a bank of six direct-form-1 biquads.
// ----------------------------------------------------------------------------
// One item is worked at a time. With enable high, an item passes through the
// accepting state, gain scaling, the term and result steps of each active
// biquad (5 filters in mode 0, 6 in mode 1) and the hold state, which loads
// the output register. A bypassed item goes from acceptance straight to the
// hold state. A stalled output register keeps the item in the hold state.
// The schedule is set by the single shared multiply-accumulate unit (five
// terms per biquad, two-stage pipeline) and the one history read and write
// per biquad in the history memory. The next item is accepted while the
// previous result still waits in the output register. The histories reset to
// zero at once through per-entry valid bits; there is no clearing pass. The
// configuration port is always ready.
// ----------------------------------------------------------------------------
module mono_to_six_channel_biquad_upmix (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sample_in
    input  logic [upm_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // left_out, center_out, left_side_out, right_side_out, right_out, lfe_out
    output logic [upm_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [upm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [upm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam logic [upm_pkg::TERM_W-1:0] K_GAIN_ONE  = 3'd0;
    localparam logic [upm_pkg::TERM_W-1:0] K_GAIN_TWO  = 3'd1;
    localparam logic [upm_pkg::TERM_W-1:0] K_TAKE_ONE  = 3'd2;
    localparam logic [upm_pkg::TERM_W-1:0] K_TAKE_TWO  = 3'd3;
    localparam logic [upm_pkg::TERM_W-1:0] K_TERM_X    = 3'd0;
    localparam logic [upm_pkg::TERM_W-1:0] K_TERM_X1   = 3'd1;
    localparam logic [upm_pkg::TERM_W-1:0] K_TERM_X2   = 3'd2;
    localparam logic [upm_pkg::TERM_W-1:0] K_TERM_Y1   = 3'd3;
    localparam logic [upm_pkg::TERM_W-1:0] K_TERM_Y2   = 3'd4;
    localparam logic [upm_pkg::TERM_W-1:0] K_RESULT    = 3'd6;
    localparam logic [upm_pkg::FILT_AW-1:0] LAST_FILT  = upm_pkg::FILT_AW'(upm_pkg::NUM_FILT - 1);
    localparam logic [upm_pkg::FILT_AW-1:0] LAST_FILT_M0 =
        upm_pkg::FILT_AW'(upm_pkg::NUM_FILT - 2);

    // Configuration registers
    logic            r_enable;
    logic            r_mode;
    upm_pkg::t_gain  r_gain_one;
    upm_pkg::t_gain  r_gain_two;

    upm_pkg::t_state                r_state, n_state;
    logic [upm_pkg::TERM_W-1:0]     r_k, n_k;
    logic [upm_pkg::FILT_AW-1:0]    r_slot, n_slot;
    upm_pkg::t_sample               r_x_in, n_x_in;
    upm_pkg::t_sample               r_xg1, n_xg1;
    upm_pkg::t_sample               r_xg2, n_xg2;
    upm_pkg::t_sample               r_ch [upm_pkg::NUM_CH];
    upm_pkg::t_sample               n_ch [upm_pkg::NUM_CH];
    upm_pkg::t_sample               r_out [upm_pkg::NUM_CH];
    upm_pkg::t_sample               n_out [upm_pkg::NUM_CH];
    logic                           r_out_valid, n_out_valid;

    upm_pkg::t_mac_op               mac_op;
    upm_pkg::t_sample               mac_a;
    upm_pkg::t_mul_b                mac_b;
    upm_pkg::t_sample               mac_y;

    logic                           rd_en;
    logic [upm_pkg::FILT_AW-1:0]    rd_addr;
    upm_pkg::t_hist                 rd_data;
    logic                           wr_en;
    upm_pkg::t_hist                 wr_data;

    logic                           slot_g1;
    logic                           slot_last;
    logic [upm_pkg::FILT_AW-1:0]    slot_chan;
    upm_pkg::t_sample               slot_x;
    upm_pkg::t_sample               term_a;
    upm_pkg::t_sample               sample_in;

    assign sample_in   = upm_pkg::t_sample'(i_s_tdata[upm_pkg::SAMPLE_WIDTH-1:0]);
    assign o_s_tready  = (r_state == upm_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;

    always_comb begin
        o_m_tdata = '0;
        for (int i = 0; i < upm_pkg::NUM_CH; i++) begin
            o_m_tdata[i*upm_pkg::SAMPLE_WIDTH +: upm_pkg::SAMPLE_WIDTH] = r_out[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b1;
            r_mode     <= 1'b1;
            r_gain_one <= upm_pkg::GAIN_RESET;
            r_gain_two <= upm_pkg::GAIN_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                upm_pkg::REG_ENABLE:   r_enable   <= i_cfg_data[0];
                upm_pkg::REG_MODE:     r_mode     <= i_cfg_data[0];
                upm_pkg::REG_GAIN_ONE: r_gain_one <= i_cfg_data;
                upm_pkg::REG_GAIN_TWO: r_gain_two <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Routing: mode 1 sends filter f to channel f; mode 0 shifts the filters
    // up by one channel, puts the scaled input on left and leaves LPF2 idle.
    always_comb begin
        if (r_mode) begin
            slot_g1   = (r_slot <= 3'd2);
            slot_last = (r_slot == LAST_FILT);
            slot_chan = r_slot;
        end else begin
            slot_g1   = (r_slot <= 3'd1);
            slot_last = (r_slot == LAST_FILT_M0);
            slot_chan = 3'(r_slot + 3'd1);
        end
        slot_x = slot_g1 ? r_xg1 : r_xg2;
        case (r_k)
            K_TERM_X:  term_a = slot_x;
            K_TERM_X1: term_a = rd_data.x1;
            K_TERM_X2: term_a = rd_data.x2;
            K_TERM_Y1: term_a = rd_data.y1;
            K_TERM_Y2: term_a = rd_data.y2;
            default:   term_a = slot_x;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_slot      = r_slot;
        n_x_in      = r_x_in;
        n_xg1       = r_xg1;
        n_xg2       = r_xg2;
        n_ch        = r_ch;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_m_tready;
        mac_op      = '0;
        mac_a       = r_x_in;
        mac_b       = '0;
        rd_en       = 1'b0;
        rd_addr     = r_slot;
        wr_en       = 1'b0;
        wr_data.x1  = slot_x;
        wr_data.x2  = rd_data.x1;
        wr_data.y1  = mac_y;
        wr_data.y2  = rd_data.y1;

        case (r_state)
            upm_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_x_in = sample_in;
                    n_k    = '0;
                    if (r_enable) begin
                        n_state = upm_pkg::ST_GAIN;
                    end else begin
                        for (int i = 0; i < upm_pkg::NUM_CH; i++) begin
                            n_ch[i] = '0;
                        end
                        n_ch[0] = sample_in;
                        n_state = upm_pkg::ST_HOLD;
                    end
                end
            end
            upm_pkg::ST_GAIN: begin
                n_k = 3'(r_k + 3'd1);
                case (r_k)
                    K_GAIN_ONE: begin
                        mac_op = '{valid: 1'b1, load: 1'b1, gain: 1'b1};
                        mac_b  = upm_pkg::t_mul_b'(r_gain_one);
                    end
                    K_GAIN_TWO: begin
                        mac_op = '{valid: 1'b1, load: 1'b1, gain: 1'b1};
                        mac_b  = upm_pkg::t_mul_b'(r_gain_two);
                    end
                    K_TAKE_ONE: begin
                        n_xg1   = mac_y;
                        n_slot  = '0;
                        rd_en   = 1'b1;
                        rd_addr = '0;
                    end
                    K_TAKE_TWO: begin
                        n_xg2   = mac_y;
                        n_ch[0] = r_xg1;
                        n_k     = '0;
                        n_state = upm_pkg::ST_MAC;
                    end
                    default: ;
                endcase
            end
            upm_pkg::ST_MAC: begin
                n_k = 3'(r_k + 3'd1);
                if (r_k <= K_TERM_Y2) begin
                    mac_op = '{valid: 1'b1, load: (r_k == K_TERM_X), gain: 1'b0};
                    mac_a  = term_a;
                    mac_b  = upm_pkg::t_mul_b'(upm_pkg::coef_sel(r_slot, r_k));
                end else if (r_k == K_RESULT) begin
                    wr_en           = 1'b1;
                    n_ch[slot_chan] = mac_y;
                    n_k             = '0;
                    if (slot_last) begin
                        n_state = upm_pkg::ST_HOLD;
                    end else begin
                        n_slot  = 3'(r_slot + 3'd1);
                        rd_en   = 1'b1;
                        rd_addr = 3'(r_slot + 3'd1);
                    end
                end
            end
            upm_pkg::ST_HOLD: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out       = r_ch;
                    n_out_valid = 1'b1;
                    n_state     = upm_pkg::ST_IDLE;
                end
            end
            default: n_state = upm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= upm_pkg::ST_IDLE;
            r_k         <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_slot      <= n_slot;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x_in <= n_x_in;
        r_xg1  <= n_xg1;
        r_xg2  <= n_xg2;
        r_ch   <= n_ch;
        r_out  <= n_out;
    end

    upm_hist_ram u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_slot),
        .i_wr_data (wr_data)
    );

    upm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (mac_op),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_y     (mac_y)
    );

`ifndef SYNTHESIS
    a_no_rw_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_en && wr_en) |-> (rd_addr != r_slot))
        else $error("history read and write hit the same entry");

    a_write_only_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> r_enable)
        else $error("history written while bypassed");

    a_lpf2_idle_mode0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && !r_mode) |-> (r_slot != LAST_FILT))
        else $error("LPF2 history written in mode 0");

    a_out_from_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == upm_pkg::ST_HOLD))
        else $error("output register loaded outside the hold state");

    a_accept_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state != upm_pkg::ST_IDLE))
        else $error("accepted item did not start processing");
`endif

endmodule
